>>> design/mie_pkg.sv
package mie_pkg;

  // default internal operand width
  localparam int unsigned DefWidth = 32;

  // width of the payload fields on the ports
  localparam int unsigned DataW = 32;

  // input word: value and modulus
  typedef struct packed {
    logic [DataW-1:0] value;
    logic [DataW-1:0] modulus;
  } in_word_t;

  // output word: inverse and no-inverse flag
  typedef struct packed {
    logic [DataW-1:0] inverse;
    logic             no_inverse;
  } out_word_t;

  // handshake between sequencer and divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

>>> design/mie_div.sv
module mie_div import mie_pkg::*; #(
  parameter int unsigned Width = DefWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  input  logic [Width-1:0] mult_i,
  output div_rsp_t         rsp_o,
  output logic [Width-1:0] rem_o,
  output logic [Width-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(Width);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] shf_q, shf_d;
  logic [Width-1:0] acc_q, acc_d;
  logic [Width:0]   trial;
  logic [Width:0]   diff;
  logic             ge;

  // one restoring step: shift in the next dividend bit and try to subtract
  assign trial = {rem_q, shf_q[Width-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = ~diff[Width];

  // step control, remainder and quotient-times-multiplier accumulation
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    shf_d  = shf_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Width - 1);
      rem_d  = '0;
      shf_d  = dividend_i;
      acc_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[Width-1:0] : trial[Width-1:0];
      shf_d = {shf_q[Width-2:0], 1'b0};
      acc_d = {acc_q[Width-2:0], 1'b0} + (ge ? mult_i : '0);
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rem_o      = rem_q;
  assign prod_o     = acc_q;

endmodule

>>> design/modular_inverse_ext_euclid_top.sv
// Modular inverse by the extended Euclidean algorithm.
//
// Input channel (in_valid_i / in_ready_o / in_word_i) carries a value and a
// modulus; output channel (out_valid_o / out_ready_i / out_word_o) returns
// the inverse of the value modulo the modulus, or 0 with no_inverse set
// when the gcd is not 1, the value is 0 or the modulus is below 2.
// Operands are taken as the low WIDTH bits of the 32-bit fields.
//
// One word is worked on at a time; in_ready_o is high only while idle.
// Each Euclid step runs through one shared restoring divider that also
// accumulates quotient times coefficient, one bit per cycle. A 32-bit
// word takes up to about 46 steps. A zero value or a small modulus goes
// from the loop state straight to done; a value of 1 passes through the
// modular and sign fix-up states before done.
//
// The result sits in an output register; a new word may be accepted while
// it waits, and the next result holds in the sequencer until the receiver
// takes the pending one. Reset empties the output register and returns
// the sequencer to idle.
module modular_inverse_ext_euclid_top import mie_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  typedef enum logic [2:0] {
    StIdle,
    StLoop,
    StDiv,
    StFixMod,
    StFixSign,
    StDone
  } state_e;

  state_e state_q;

  logic [WIDTH-1:0] a_q, b_q, ta_q, tb_q, n_q;
  logic             neg_q;
  logic             none_q;
  logic             out_valid_q;
  out_word_t        out_word_q;

  logic [WIDTH-1:0] v_in, n_in;
  logic [WIDTH-1:0] div_rem, div_prod;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             out_free;

  assign v_in = WIDTH'(in_word_i.value);
  assign n_in = WIDTH'(in_word_i.modulus);

  assign in_ready_o = (state_q == StIdle);
  assign out_free   = ~out_valid_q | out_ready_i;

  // in the loop state, start a division whenever the remainder is neither 0 nor 1
  assign div_req.start = (state_q == StLoop) && (b_q > WIDTH'(1));

  mie_div #(
    .Width (WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .mult_i     (tb_q),
    .rsp_o      (div_rsp),
    .rem_o      (div_rem),
    .prod_o     (div_prod)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      // pending word taken and no new one loading behind it
      if (out_valid_q && out_ready_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StLoop;
          end
        end
        StLoop: begin
          if (b_q == WIDTH'(1)) begin
            state_q <= StFixMod;
          end else if (b_q == '0) begin
            state_q <= StDone;
          end else begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_rsp.done) begin
            state_q <= StLoop;
          end
        end
        StFixMod: begin
          state_q <= StFixSign;
        end
        StFixSign: begin
          state_q <= StDone;
        end
        StDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // working registers of the Euclid loop
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        a_q    <= n_in;
        b_q    <= v_in;
        ta_q   <= '0;
        tb_q   <= WIDTH'(1);
        n_q    <= n_in;
        neg_q  <= 1'b0;
        none_q <= 1'b1;
        // small modulus: no ring, force the no-inverse path
        if (n_in < WIDTH'(2)) begin
          b_q <= '0;
        end
      end
      StLoop: begin
        if (b_q == WIDTH'(1)) begin
          none_q <= 1'b0;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          a_q   <= b_q;
          b_q   <= div_rem;
          ta_q  <= tb_q;
          tb_q  <= div_prod + ta_q;
          neg_q <= ~neg_q;
        end
      end
      StFixMod: begin
        if (tb_q >= n_q) begin
          tb_q <= tb_q - n_q;
        end
      end
      StFixSign: begin
        if (neg_q && (tb_q != '0)) begin
          tb_q <= n_q - tb_q;
        end
      end
      StDone: begin
        if (out_free) begin
          out_word_q.inverse    <= none_q ? '0 : DataW'(tb_q);
          out_word_q.no_inverse <= none_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> sim/modular_inverse_ext_euclid_top_tb.sv
module modular_inverse_ext_euclid_top_tb;
  import mie_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OpW = DefWidth;
  localparam int unsigned MaxShown = 10;
  localparam int unsigned TailCycles = 2000;
  localparam int unsigned HoldOffCycles = 3000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  // words waiting to be sent, inverses waiting to come back
  in_word_t  pend_words[$];
  out_word_t inverse_q[$];
  out_word_t want_word;

  logic        word_taken;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned errors;
  int unsigned words_in;
  int unsigned results_seen;
  int unsigned none_seen;
  int unsigned input_stalls;
  longint unsigned fib [0:47];

  modular_inverse_ext_euclid_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // extended euclid, coefficient of the value kept as magnitude plus sign
  function automatic out_word_t modinv_predict(in_word_t w);
    longint unsigned mask, v, n, a, b, ta, tb, q, r, tn;
    bit neg;
    out_word_t res;
    mask = (OpW >= 64) ? '1 : ((64'd1 << OpW) - 1);
    v = longint'(w.value) & mask;
    n = longint'(w.modulus) & mask;
    res.inverse = '0;
    res.no_inverse = 1'b1;
    if (n < 2) return res;
    if (v == 1) begin
      res.inverse = 1;
      res.no_inverse = 1'b0;
      return res;
    end
    a = n;
    b = v;
    ta = 0;
    tb = 1;
    neg = 1'b0;
    while (b != 1) begin
      // remainder hit zero first: gcd is not one
      if (b == 0) return res;
      q = a / b;
      r = a - q * b;
      tn = ta + q * tb;
      a = b;
      b = r;
      ta = tb;
      tb = tn;
      neg = !neg;
    end
    if (tb >= n) tb = tb % n;
    if (neg && tb != 0) tb = n - tb;
    res.inverse = tb[DataW-1:0];
    res.no_inverse = 1'b0;
    return res;
  endfunction

  function automatic in_word_t make_word(longint unsigned v, longint unsigned n);
    in_word_t w;
    w.value = v[DataW-1:0];
    w.modulus = n[DataW-1:0];
    return w;
  endfunction

  // random word drawn from a mix of operand shapes
  function automatic in_word_t rand_word();
    int unsigned sel, g, k;
    longint unsigned n;
    in_word_t w;
    sel = $urandom_range(99);
    if (sel < 25) begin
      w.value = $urandom;
      w.modulus = $urandom;
    end else if (sel < 50) begin
      w.modulus = $urandom_range(65535, 2);
      w.value = ($urandom_range(3) == 0) ? $urandom : $urandom % w.modulus;
    end else if (sel < 65) begin
      // common factor on both sides
      g = $urandom_range(200, 2);
      w.value = g * $urandom_range(1 << 20, 0);
      w.modulus = g * $urandom_range(1 << 20, 1);
    end else if (sel < 72) begin
      n = $urandom_range(32'hFFFF_FFFF, 2);
      case ($urandom_range(4))
        0: w = make_word(0, n);
        1: w = make_word(1, n);
        2: w = make_word(n - 1, n);
        3: w = make_word(n, n);
        default: w = make_word(n + 1, n);
      endcase
    end else if (sel < 77) begin
      w.value = $urandom;
      w.modulus = 32'hFFFF_FFFB;
    end else if (sel < 80) begin
      // consecutive fibonacci numbers give the longest runs
      k = $urandom_range(46, 20);
      w = $urandom_range(1) ? make_word(fib[k], fib[k+1]) : make_word(fib[k+1], fib[k]);
    end else if (sel < 83) begin
      w.value = $urandom;
      w.modulus = $urandom_range(1);
    end else begin
      w.modulus = $urandom_range(32'hFF_FFFF, 2);
      w.value = $urandom & 32'hFF_FFFF;
    end
    return w;
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= MaxShown) $display("%0t: %s", $time, msg);
  endtask

  task automatic wait_drained();
    while (pend_words.size() != 0 || in_valid_i || inverse_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned gap, int unsigned stall, int unsigned count);
    @(posedge clk_i);
    send_gap_pct = gap;
    recv_stall_pct = stall;
    repeat (count) pend_words.push_back(rand_word());
    wait_drained();
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (pend_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_word_i <= pend_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output ready, with a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted words, check returned inverses
  always @(posedge clk_i) begin
    word_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && !in_ready_o) input_stalls++;
    if (rst_ni && in_valid_i && in_ready_o) begin
      inverse_q.push_back(modinv_predict(in_word_i));
      words_in++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_word_o.no_inverse) none_seen++;
      if (inverse_q.size() == 0) begin
        flag_error($sformatf("result with nothing pending: inverse %0d no_inverse %0d",
                             out_word_o.inverse, out_word_o.no_inverse));
      end else begin
        want_word = inverse_q.pop_front();
        if (out_word_o.inverse !== want_word.inverse)
          flag_error($sformatf("inverse mismatch: expected %0d got %0d",
                               want_word.inverse, out_word_o.inverse));
        if (out_word_o.no_inverse !== want_word.no_inverse)
          flag_error($sformatf("no_inverse mismatch: expected %0d got %0d",
                               want_word.no_inverse, out_word_o.no_inverse));
      end
    end
  end

  // run time limit
  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", inverse_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // main sequence
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_ready_i = 1'b0;
    word_taken = 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    errors = 0;
    words_in = 0;
    results_seen = 0;
    none_seen = 0;
    input_stalls = 0;
    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i < 48; i++) fib[i] = fib[i-1] + fib[i-2];
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners, no idling
    @(posedge clk_i);
    pend_words.push_back(make_word(0, 7));
    pend_words.push_back(make_word(1, 2));
    pend_words.push_back(make_word(1, 32'hFFFF_FFFF));
    pend_words.push_back(make_word(3, 7));
    pend_words.push_back(make_word(2, 3));
    pend_words.push_back(make_word(10, 3));
    pend_words.push_back(make_word(6, 9));
    pend_words.push_back(make_word(12345, 12345));
    pend_words.push_back(make_word(32'hFFFF_FFFF, 32'hFFFF_FFFE));
    pend_words.push_back(make_word(32'hFFFF_FFFE, 32'hFFFF_FFFF));
    pend_words.push_back(make_word(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pend_words.push_back(make_word(32'h8000_0000, 32'hFFFF_FFFF));
    pend_words.push_back(make_word(32'h7FFF_FFFF, 32'h8000_0000));
    pend_words.push_back(make_word(2, 32'hFFFF_FFFE));
    pend_words.push_back(make_word(2, 32'hFFFF_FFFB));
    pend_words.push_back(make_word(32'hFFFF_FFFA, 32'hFFFF_FFFB));
    pend_words.push_back(make_word(fib[46], fib[47]));
    pend_words.push_back(make_word(fib[47], fib[46]));
    pend_words.push_back(make_word(5, 0));
    pend_words.push_back(make_word(5, 1));
    pend_words.push_back(make_word(0, 0));
    pend_words.push_back(make_word(0, 1));
    pend_words.push_back(make_word(1, 0));
    pend_words.push_back(make_word(1, 1));
    wait_drained();

    // long output hold-off while the sender keeps offering small words
    @(posedge clk_i);
    hold_left = HoldOffCycles;
    for (int i = 0; i < 8; i++)
      pend_words.push_back(make_word($urandom_range(999, 2), $urandom_range(1000, 3)));
    while (hold_left != 0) @(posedge clk_i);
    wait_drained();

    // random words under each idling mix
    run_phase(0, 0, 85);
    run_phase(63, 0, 85);
    run_phase(0, 63, 85);
    run_phase(23, 23, 85);

    repeat (TailCycles) @(posedge clk_i);
    if (inverse_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", inverse_q.size()));
    $display("%0d words in, %0d results checked (%0d without inverse), %0d input stall cycles",
             words_in, results_seen, none_seen, input_stalls);
    $display("covered corners, long hold-off, and sender/receiver idle mixes; %0d errors",
             errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
